// ===== rtl/core/swd_bte_pkg.sv =====
// Package for the SWD bit transfer engine: action, acknowledge and status
// codes, sequence lengths and stream widths.
// No dependencies; used by swd_bit_transfer_engine_top.
package swd_bte_pkg;

    // Kinds of input request (carried on tuser)
    parameter logic [1:0] ACT_TICK       = 2'd0;
    parameter logic [1:0] ACT_START_XFER = 2'd1;
    parameter logic [1:0] ACT_START_JSEQ = 2'd2;

    // Acknowledge codes, as received LSB first
    parameter logic [2:0] ACK_OK    = 3'b001;
    parameter logic [2:0] ACK_WAIT  = 3'b010;
    parameter logic [2:0] ACK_FAULT = 3'b100;

    // Transfer status codes
    parameter logic [2:0] ST_OK        = 3'd0;
    parameter logic [2:0] ST_WAIT      = 3'd1;
    parameter logic [2:0] ST_FAULT     = 3'd2;
    parameter logic [2:0] ST_PARITY    = 3'd3;
    parameter logic [2:0] ST_PROTOCOL  = 3'd4;

    // Turnaround length limits
    parameter logic [2:0] TURN_MIN = 3'd1;
    parameter logic [2:0] TURN_MAX = 3'd4;
    parameter logic [2:0] TURN_RST = 3'd1;

    // Bit counter marks (count width 7)
    parameter int unsigned CNT_W = 7;
    parameter logic [CNT_W-1:0] REQ_PARITY  = 7'd5;
    parameter logic [CNT_W-1:0] REQ_STOP    = 7'd6;
    parameter logic [CNT_W-1:0] REQ_LAST    = 7'd7;
    parameter logic [CNT_W-1:0] ACK_LAST    = 7'd2;
    parameter logic [CNT_W-1:0] DATA_BITS   = 7'd32;
    parameter logic [CNT_W-1:0] BACKOFF_LEN = 7'd34;
    parameter logic [CNT_W-1:0] HIGH_RUN    = 7'd51;
    parameter logic [CNT_W-1:0] SWITCH_END  = 7'd67;   // 51 + 16
    parameter logic [CNT_W-1:0] HIGH_END    = 7'd118;  // 2*51 + 16
    parameter logic [CNT_W-1:0] JSEQ_LAST   = 7'd120;  // 2*51 + 16 + 3 - 1

    parameter logic [15:0] SWITCH_WORD = 16'hE79E;

    // Stream widths
    parameter int unsigned IN_DATA_W  = 40;
    parameter int unsigned IN_USER_W  = 2;
    parameter int unsigned OUT_DATA_W = 40;

endpackage

// ===== rtl/core/swd_bit_transfer_engine_top.sv =====
// Top level of the SWD bit transfer engine: host side of a Serial Wire
// Debug link, one line cycle per tick request.
// Depends on swd_bte_pkg.

// Usage
//   Slave stream: one request per SWCLK cycle. tuser carries the action
//   (tick, start transfer, start JTAG-to-SWD switch); tdata carries the
//   request fields, the write word and the sampled SWDIO level.
//   Master stream: one result per tick clocked while busy, giving the
//   level and drive enable for SWDIO; tlast marks a transfer's or
//   sequence's final cycle, where status, ack and read word are valid.
//   Start requests, ticks while idle and starts while busy give no result.
//   Config: i_cfg_wr_en writes the turnaround length (1..4, reset 1);
//   write it only while idle.
// Timing
//   A result is registered when its request is taken. One request is
//   taken every cycle while s_axis_tready is high: the next state is worked
//   out in a single pass from the registered state and the incoming request.
//   A two-entry output stage (output register plus skid register) keeps
//   s_axis_tready registered; it drops only while both entries are full.
// Reset
//   Synchronous, active low: engine idle, both output entries empty,
//   turnaround length back to TURN_RST.
module swd_bit_transfer_engine_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration
    input  logic        i_cfg_wr_en,
    input  logic [2:0]  i_cfg_wr_data,    // turnaround_cycles
    // Request stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [0] ap_not_dp, [1] read_not_write, [3:2] reg_addr, [35:4] write_data,
    // [36] line_in, [39:37] zero
    input  logic [swd_bte_pkg::IN_DATA_W-1:0] s_axis_tdata,
    // [1:0] action
    input  logic [swd_bte_pkg::IN_USER_W-1:0] s_axis_tuser,
    // Result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [0] line_out, [1] drive_enable, [4:2] status, [7:5] ack_bits,
    // [39:8] read_data
    output logic [swd_bte_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    output logic        m_axis_tlast        // last
);

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_REQ,
        PH_TURN1,
        PH_ACK,
        PH_RDATA,
        PH_TURN_END,
        PH_TURN_W,
        PH_WDATA,
        PH_BACKOFF,
        PH_JSEQ
    } t_phase;

    // Engine state
    t_phase      r_phase, n_phase;
    logic [6:0]  r_bit_count, n_bit_count;
    logic [31:0] r_shift_word, n_shift_word;
    logic        r_parity_acc, n_parity_acc;
    logic [2:0]  r_ack_reg, n_ack_reg;
    logic [3:0]  r_request_reg, n_request_reg;
    logic [2:0]  r_turn_cfg;

    // Output stage
    logic        r_out_valid, r_skid_valid;
    logic [39:0] r_out_data, r_skid_data;
    logic        r_out_last, r_skid_last;

    // Request decode
    logic        in_accept;
    logic [1:0]  in_action;
    logic        in_ap_not_dp, in_read_not_write, in_line;
    logic [1:0]  in_reg_addr;
    logic [31:0] in_write_data;

    // Result of this pass
    logic        res_valid;
    logic        res_line, res_de, res_last;
    logic [2:0]  res_status, res_ack;
    logic [31:0] res_rdata;
    logic [39:0] res_data;

    logic [2:0]  turn_len;
    logic [6:0]  cnt_inc;
    logic [6:0]  jseq_idx;
    logic [2:0]  ack_next;
    logic        turn_done;
    logic        out_pop;

    assign in_accept         = s_axis_tvalid && s_axis_tready;
    assign in_action         = s_axis_tuser[1:0];
    assign in_ap_not_dp      = s_axis_tdata[0];
    assign in_read_not_write = s_axis_tdata[1];
    assign in_reg_addr       = s_axis_tdata[3:2];
    assign in_write_data     = s_axis_tdata[35:4];
    assign in_line           = s_axis_tdata[36];

    // Clamp the turnaround length into 1..4
    always_comb begin
        if (r_turn_cfg < swd_bte_pkg::TURN_MIN) begin
            turn_len = swd_bte_pkg::TURN_MIN;
        end else if (r_turn_cfg > swd_bte_pkg::TURN_MAX) begin
            turn_len = swd_bte_pkg::TURN_MAX;
        end else begin
            turn_len = r_turn_cfg;
        end
    end

    assign cnt_inc   = r_bit_count + 7'd1;
    assign turn_done = (cnt_inc >= {4'd0, turn_len});
    assign jseq_idx  = r_bit_count - swd_bte_pkg::HIGH_RUN;

    // Fold the sampled ack bit into place
    always_comb begin
        ack_next = r_ack_reg;
        unique case (r_bit_count[1:0])
            2'd0:    ack_next[0] = r_ack_reg[0] | in_line;
            2'd1:    ack_next[1] = r_ack_reg[1] | in_line;
            2'd2:    ack_next[2] = r_ack_reg[2] | in_line;
            default: ack_next = r_ack_reg;
        endcase
    end

    // Single pass: next state and result from the state and the request
    always_comb begin
        n_phase       = r_phase;
        n_bit_count   = r_bit_count;
        n_shift_word  = r_shift_word;
        n_parity_acc  = r_parity_acc;
        n_ack_reg     = r_ack_reg;
        n_request_reg = r_request_reg;
        res_valid     = 1'b0;
        res_line      = 1'b0;
        res_de        = 1'b0;
        res_last      = 1'b0;
        res_status    = swd_bte_pkg::ST_OK;
        res_ack       = 3'd0;
        res_rdata     = 32'd0;

        if (in_action == swd_bte_pkg::ACT_START_XFER
            || in_action == swd_bte_pkg::ACT_START_JSEQ) begin
            // Latch a new transfer or sequence; busy starts are dropped
            if (r_phase == PH_IDLE) begin
                n_bit_count  = 7'd0;
                n_parity_acc = 1'b0;
                if (in_action == swd_bte_pkg::ACT_START_XFER) begin
                    n_request_reg = {in_reg_addr, in_read_not_write, in_ap_not_dp};
                    n_shift_word  = in_write_data;
                    n_ack_reg     = 3'd0;
                    n_phase       = PH_REQ;
                end else begin
                    n_phase = PH_JSEQ;
                end
            end
        end else if (in_action == swd_bte_pkg::ACT_TICK && r_phase != PH_IDLE) begin
            res_valid   = 1'b1;
            n_bit_count = cnt_inc;
            unique case (r_phase)
                PH_REQ: begin
                    res_de = 1'b1;
                    if (r_bit_count == 7'd0) begin
                        res_line = 1'b1;
                    end else if (r_bit_count < swd_bte_pkg::REQ_PARITY) begin
                        res_line = r_request_reg[r_bit_count[1:0] - 2'd1];
                    end else if (r_bit_count == swd_bte_pkg::REQ_PARITY) begin
                        res_line = ^r_request_reg;
                    end else if (r_bit_count == swd_bte_pkg::REQ_STOP) begin
                        res_line = 1'b0;
                    end else begin
                        res_line = 1'b1;
                    end
                    if (r_bit_count >= swd_bte_pkg::REQ_LAST) begin
                        n_phase     = PH_TURN1;
                        n_bit_count = 7'd0;
                    end
                end
                PH_TURN1: begin
                    if (turn_done) begin
                        n_phase     = PH_ACK;
                        n_bit_count = 7'd0;
                    end
                end
                PH_ACK: begin
                    n_ack_reg = ack_next;
                    if (r_bit_count >= swd_bte_pkg::ACK_LAST) begin
                        n_bit_count = 7'd0;
                        if (ack_next == swd_bte_pkg::ACK_OK) begin
                            if (r_request_reg[1]) begin
                                n_phase      = PH_RDATA;
                                n_shift_word = 32'd0;
                                n_parity_acc = 1'b0;
                            end else begin
                                n_phase = PH_TURN_W;
                            end
                        end else if (ack_next == swd_bte_pkg::ACK_WAIT
                                     || ack_next == swd_bte_pkg::ACK_FAULT) begin
                            n_phase = PH_TURN_END;
                        end else begin
                            n_phase = PH_BACKOFF;
                        end
                    end
                end
                PH_RDATA: begin
                    n_parity_acc = r_parity_acc ^ in_line;
                    if (r_bit_count < swd_bte_pkg::DATA_BITS) begin
                        n_shift_word = {in_line, r_shift_word[31:1]};
                    end else begin
                        n_phase     = PH_TURN_END;
                        n_bit_count = 7'd0;
                    end
                end
                PH_TURN_END: begin
                    if (turn_done) begin
                        res_last = 1'b1;
                        res_ack  = r_ack_reg;
                        if (r_ack_reg == swd_bte_pkg::ACK_OK) begin
                            res_status = r_parity_acc ? swd_bte_pkg::ST_PARITY
                                                      : swd_bte_pkg::ST_OK;
                            if (r_request_reg[1]) begin
                                res_rdata = r_shift_word;
                            end
                        end else if (r_ack_reg == swd_bte_pkg::ACK_WAIT) begin
                            res_status = swd_bte_pkg::ST_WAIT;
                        end else begin
                            res_status = swd_bte_pkg::ST_FAULT;
                        end
                    end
                end
                PH_TURN_W: begin
                    if (turn_done) begin
                        n_phase      = PH_WDATA;
                        n_bit_count  = 7'd0;
                        n_parity_acc = 1'b0;
                    end
                end
                PH_WDATA: begin
                    res_de = 1'b1;
                    if (r_bit_count < swd_bte_pkg::DATA_BITS) begin
                        res_line     = r_shift_word[0];
                        n_parity_acc = r_parity_acc ^ r_shift_word[0];
                        n_shift_word = {1'b0, r_shift_word[31:1]};
                    end else begin
                        res_line = r_parity_acc;
                        res_last = 1'b1;
                        res_ack  = r_ack_reg;
                    end
                end
                PH_BACKOFF: begin
                    if (cnt_inc >= swd_bte_pkg::BACKOFF_LEN) begin
                        res_last   = 1'b1;
                        res_status = swd_bte_pkg::ST_PROTOCOL;
                        res_ack    = r_ack_reg;
                    end
                end
                PH_JSEQ: begin
                    res_de = 1'b1;
                    if (r_bit_count < swd_bte_pkg::HIGH_RUN) begin
                        res_line = 1'b1;
                    end else if (r_bit_count < swd_bte_pkg::SWITCH_END) begin
                        res_line = swd_bte_pkg::SWITCH_WORD[jseq_idx[3:0]];
                    end else if (r_bit_count < swd_bte_pkg::HIGH_END) begin
                        res_line = 1'b1;
                    end else begin
                        res_line = 1'b0;
                    end
                    if (r_bit_count >= swd_bte_pkg::JSEQ_LAST) begin
                        res_last = 1'b1;
                    end
                end
                default: begin
                    res_valid = 1'b0;
                end
            endcase
            // Any end returns the engine to idle
            if (res_last) begin
                n_phase     = PH_IDLE;
                n_bit_count = 7'd0;
            end
        end
    end

    assign res_data = {res_rdata, res_ack, res_status, res_de, res_line};

    // Engine state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_bit_count <= 7'd0;
            r_turn_cfg  <= swd_bte_pkg::TURN_RST;
        end else begin
            if (i_cfg_wr_en) begin
                r_turn_cfg <= i_cfg_wr_data;
            end
            if (in_accept) begin
                r_phase     <= n_phase;
                r_bit_count <= n_bit_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_shift_word  <= n_shift_word;
            r_parity_acc  <= n_parity_acc;
            r_ack_reg     <= n_ack_reg;
            r_request_reg <= n_request_reg;
        end
    end

    // Output register plus skid register; hold the skid entry until the
    // output register drains
    assign out_pop       = r_out_valid && m_axis_tready;
    assign s_axis_tready = !r_skid_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (out_pop) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end
        end else if (in_accept && res_valid) begin
            if (!r_out_valid || out_pop) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (out_pop) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (out_pop) begin
                r_out_data <= r_skid_data;
                r_out_last <= r_skid_last;
            end
        end else if (in_accept && res_valid) begin
            if (!r_out_valid || out_pop) begin
                r_out_data <= res_data;
                r_out_last <= res_last;
            end else begin
                r_skid_data <= res_data;
                r_skid_last <= res_last;
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tlast  = r_out_last;

    // Checks
    // The skid entry is only ever filled behind a full output register
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry valid with empty output register");

    // Idle engine carries a cleared bit counter
    a_idle_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_IDLE) |-> (r_bit_count == 7'd0))
        else $error("bit counter not cleared in idle");

    // A transfer start taken while idle moves into the request phase
    a_start_xfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && in_action == swd_bte_pkg::ACT_START_XFER && r_phase == PH_IDLE)
        |=> (r_phase == PH_REQ))
        else $error("transfer start did not enter request phase");

    // A final-cycle result always sends the engine back to idle
    a_last_idles: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && res_valid && res_last) |=> (r_phase == PH_IDLE))
        else $error("engine not idle after final cycle");

endmodule

// ===== bench/swd_bit_transfer_engine_top_tb.sv =====
// Self-checking bench for the SWD bit transfer engine: a short directed request table,
// then random transfers and switch sequences under several turnaround settings.
// Depends on swd_bte_pkg and swd_bit_transfer_engine_top.
module swd_bit_transfer_engine_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // Action code the block must ignore (the fourth value of tuser)
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    localparam int CYCLE_LIMIT       = 400000;
    localparam int SETTLE_CYCLES     = 8;
    localparam int HOLD_CYCLES       = 300;
    localparam int ITEMS_PER_SETTING = 275;

    // One request on the slave stream
    typedef struct packed {
        logic [1:0]  action;
        logic        apndp;
        logic        rnw;
        logic [1:0]  addr;
        logic [31:0] wdata;
        logic        line;
    } t_swd_req;

    // One line cycle on the master stream
    typedef struct packed {
        logic        line;
        logic        drive;
        logic        last;
        logic [2:0]  status;
        logic [2:0]  ack;
        logic [31:0] rdata;
    } t_swd_cycle;

    // Directed row: the request, and a typed-in result where one is given
    typedef struct packed {
        t_swd_req   req;
        logic       typed;
        t_swd_cycle want;
    } t_dir_row;

    typedef enum logic [3:0] {
        ENG_IDLE, ENG_REQUEST, ENG_TURN_A, ENG_ACK, ENG_READ,
        ENG_TURN_END, ENG_TURN_W, ENG_WRITE, ENG_BACKOFF, ENG_SWITCH
    } t_eng_phase;

    localparam t_swd_req TICK0 = '{swd_bte_pkg::ACT_TICK, 1'b0, 1'b0, 2'd0, 32'd0, 1'b0};
    localparam t_swd_req TICK1 = '{swd_bte_pkg::ACT_TICK, 1'b0, 1'b0, 2'd0, 32'd0, 1'b1};
    localparam t_swd_req JSEQ0 = '{swd_bte_pkg::ACT_START_JSEQ, 1'b0, 1'b0, 2'd0, 32'd0,
                                   1'b0};

    localparam t_swd_cycle NO_CYCLE = '0;                                   // line released
    localparam t_swd_cycle DRV_1    = '{1'b1, 1'b1, 1'b0, swd_bte_pkg::ST_OK, 3'd0, 32'd0};
    localparam t_swd_cycle DRV_0    = '{1'b0, 1'b1, 1'b0, swd_bte_pkg::ST_OK, 3'd0, 32'd0};
    localparam t_swd_cycle WAIT_END = '{1'b0, 1'b0, 1'b1, swd_bte_pkg::ST_WAIT,
                                        swd_bte_pkg::ACK_WAIT, 32'd0};

    logic                               i_clk = 1'b0;
    logic                               i_rst_n;
    logic                               i_cfg_wr_en;
    logic [2:0]                         i_cfg_wr_data;
    logic                               s_axis_tvalid;
    logic                               s_axis_tready;
    logic [swd_bte_pkg::IN_DATA_W-1:0]  s_axis_tdata;
    logic [swd_bte_pkg::IN_USER_W-1:0]  s_axis_tuser;
    logic                               m_axis_tvalid;
    logic                               m_axis_tready;
    logic [swd_bte_pkg::OUT_DATA_W-1:0] m_axis_tdata;
    logic                               m_axis_tlast;

    // Engine model state
    t_eng_phase  eng_phase = ENG_IDLE;
    logic [6:0]  eng_count = '0;
    logic [31:0] eng_word  = '0;
    logic        eng_par   = 1'b0;
    logic [2:0]  eng_ack   = '0;
    logic [3:0]  eng_req   = '0;
    logic [2:0]  turn_cfg  = swd_bte_pkg::TURN_RST;

    t_swd_cycle  pending_cycles[$];     // line cycles still owed by the block
    t_dir_row    dir_rows[22];
    logic [2:0]  turn_plan[7] = '{3'd0, 3'd4, 3'd7, 3'd2, 3'd3, 3'd5, 3'd1};
    // acknowledge the target side will answer with
    logic [2:0]  planned_ack = swd_bte_pkg::ACK_OK;
    int          items_sent = 0;
    int          fail_count = 0;
    int unsigned cycle_cnt = 0;
    bit          tx_gaps = 1'b1;
    bit          rx_gaps = 1'b1;
    bit          hold_go = 1'b0;
    logic        hold_off = 1'b0;

    swd_bit_transfer_engine_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Advance the engine model by one request. Return 1 when the request clocks a
    // line cycle, with that cycle in c.
    function automatic logic predict_line_cycle(input t_swd_req r, output t_swd_cycle c);
        logic [6:0] n;
        logic [6:0] k;
        logic [2:0] t;
        logic       done;
        c    = NO_CYCLE;
        n    = eng_count;
        k    = n - swd_bte_pkg::HIGH_RUN;
        done = 1'b0;
        // clamp the turnaround: zero behaves as the minimum, anything above four as four
        t = (turn_cfg < swd_bte_pkg::TURN_MIN) ? swd_bte_pkg::TURN_MIN :
            (turn_cfg > swd_bte_pkg::TURN_MAX) ? swd_bte_pkg::TURN_MAX : turn_cfg;

        // starts only latch; a start while busy is dropped
        if (r.action == swd_bte_pkg::ACT_START_XFER
            || r.action == swd_bte_pkg::ACT_START_JSEQ) begin
            if (eng_phase == ENG_IDLE) begin
                eng_count = '0;
                eng_par   = 1'b0;
                if (r.action == swd_bte_pkg::ACT_START_XFER) begin
                    eng_req   = {r.addr, r.rnw, r.apndp};
                    eng_word  = r.wdata;
                    eng_ack   = '0;
                    eng_phase = ENG_REQUEST;
                end else begin
                    eng_phase = ENG_SWITCH;
                end
            end
            return 1'b0;
        end
        // the unused action and ticks while idle clock nothing
        if (r.action != swd_bte_pkg::ACT_TICK || eng_phase == ENG_IDLE) return 1'b0;

        case (eng_phase)
            ENG_REQUEST: begin
                c.drive = 1'b1;
                if (n == 0)                            c.line = 1'b1;
                else if (n <= 4)                       c.line = eng_req[n[1:0] - 2'd1];
                else if (n == swd_bte_pkg::REQ_PARITY) c.line = ^eng_req;
                else if (n == swd_bte_pkg::REQ_STOP)   c.line = 1'b0;
                else                                   c.line = 1'b1;
                eng_count = n + 7'd1;
                if (n >= swd_bte_pkg::REQ_LAST) begin
                    eng_phase = ENG_TURN_A;
                    eng_count = '0;
                end
            end
            ENG_TURN_A: begin
                eng_count = n + 7'd1;
                if (eng_count >= t) begin
                    eng_phase = ENG_ACK;
                    eng_count = '0;
                end
            end
            ENG_ACK: begin
                eng_ack[n[1:0]] = r.line;
                eng_count = n + 7'd1;
                if (n >= swd_bte_pkg::ACK_LAST) begin
                    eng_count = '0;
                    if (eng_ack == swd_bte_pkg::ACK_OK) begin
                        if (eng_req[1]) begin
                            eng_phase = ENG_READ;
                            eng_word  = '0;
                            eng_par   = 1'b0;
                        end else begin
                            eng_phase = ENG_TURN_W;
                        end
                    end else if (eng_ack == swd_bte_pkg::ACK_WAIT
                                 || eng_ack == swd_bte_pkg::ACK_FAULT) begin
                        eng_phase = ENG_TURN_END;
                    end else begin
                        eng_phase = ENG_BACKOFF;
                    end
                end
            end
            ENG_READ: begin
                eng_par = eng_par ^ r.line;
                if (n < swd_bte_pkg::DATA_BITS) begin
                    eng_word  = {r.line, eng_word[31:1]};
                    eng_count = n + 7'd1;
                end else begin
                    eng_phase = ENG_TURN_END;
                    eng_count = '0;
                end
            end
            ENG_TURN_END: begin
                eng_count = n + 7'd1;
                if (eng_count >= t) begin
                    c.last = 1'b1;
                    c.ack  = eng_ack;
                    if (eng_ack == swd_bte_pkg::ACK_OK) begin
                        c.status = eng_par ? swd_bte_pkg::ST_PARITY : swd_bte_pkg::ST_OK;
                        if (eng_req[1]) c.rdata = eng_word;
                    end else if (eng_ack == swd_bte_pkg::ACK_WAIT) begin
                        c.status = swd_bte_pkg::ST_WAIT;
                    end else begin
                        c.status = swd_bte_pkg::ST_FAULT;
                    end
                    done = 1'b1;
                end
            end
            ENG_TURN_W: begin
                eng_count = n + 7'd1;
                if (eng_count >= t) begin
                    eng_phase = ENG_WRITE;
                    eng_count = '0;
                    eng_par   = 1'b0;
                end
            end
            ENG_WRITE: begin
                c.drive = 1'b1;
                if (n < swd_bte_pkg::DATA_BITS) begin
                    c.line    = eng_word[0];
                    eng_par   = eng_par ^ eng_word[0];
                    eng_word  = eng_word >> 1;
                    eng_count = n + 7'd1;
                end else begin
                    c.line = eng_par;
                    c.last = 1'b1;
                    c.ack  = eng_ack;
                    done   = 1'b1;
                end
            end
            ENG_BACKOFF: begin
                eng_count = n + 7'd1;
                if (eng_count >= swd_bte_pkg::BACKOFF_LEN) begin
                    c.last   = 1'b1;
                    c.status = swd_bte_pkg::ST_PROTOCOL;
                    c.ack    = eng_ack;
                    done     = 1'b1;
                end
            end
            ENG_SWITCH: begin
                c.drive = 1'b1;
                if (n < swd_bte_pkg::HIGH_RUN)        c.line = 1'b1;
                else if (n < swd_bte_pkg::SWITCH_END) c.line = swd_bte_pkg::SWITCH_WORD[k[3:0]];
                else if (n < swd_bte_pkg::HIGH_END)   c.line = 1'b1;
                else                                  c.line = 1'b0;
                eng_count = n + 7'd1;
                if (eng_count > swd_bte_pkg::JSEQ_LAST) begin
                    c.last = 1'b1;
                    done   = 1'b1;
                end
            end
            default: ;
        endcase

        if (done) begin
            eng_phase = ENG_IDLE;
            eng_count = '0;
        end
        return 1'b1;
    endfunction

    function automatic t_swd_req random_fields();
        t_swd_req r;
        r.action = swd_bte_pkg::ACT_TICK;
        r.apndp  = 1'($urandom_range(0, 1));
        r.rnw    = 1'($urandom_range(0, 1));
        r.addr   = 2'($urandom_range(0, 3));
        r.wdata  = $urandom();
        r.line   = 1'($urandom_range(0, 1));
        return r;
    endfunction

    // Choose the sampled SWDIO level for the next tick: answer the planned
    // acknowledge, get the read parity right three times in four, else noise.
    function automatic logic line_for_tick();
        if (eng_phase == ENG_ACK) return planned_ack[eng_count[1:0]];
        if (eng_phase == ENG_READ && eng_count == swd_bte_pkg::DATA_BITS)
            return ($urandom_range(0, 3) == 0) ? ~eng_par : eng_par;
        return 1'($urandom_range(0, 1));
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        fail_count++;
        $display("%0t ns: %s mismatch, got %0h, want %0h", $time, what, got, want);
    endtask

    // Compare one accepted result with the oldest owed line cycle
    task automatic check_result(input logic [swd_bte_pkg::OUT_DATA_W-1:0] d, input logic l);
        t_swd_cycle want;
        if (pending_cycles.size() == 0) begin
            report_mismatch("unowed result", d[31:0], 32'd0);
            return;
        end
        want = pending_cycles.pop_front();
        if (d[0] !== want.line)      report_mismatch("line_out", d[0], want.line);
        if (d[1] !== want.drive)     report_mismatch("drive_enable", d[1], want.drive);
        if (l !== want.last)         report_mismatch("last", l, want.last);
        if (d[4:2] !== want.status)  report_mismatch("status", d[4:2], want.status);
        if (d[7:5] !== want.ack)     report_mismatch("ack_bits", d[7:5], want.ack);
        if (d[39:8] !== want.rdata)  report_mismatch("read_data", d[39:8], want.rdata);
    endtask

    // Offer one request, wait for the handshake, then work out what it owes.
    // Call at a rising edge; returns at the edge where the request is taken.
    task automatic send_request(input t_swd_req r, input logic typed,
                                input t_swd_cycle typed_cyc);
        int         gap;
        logic       was_idle;
        logic       has_cyc;
        t_swd_cycle cyc;
        gap = tx_gaps ? $urandom_range(0, 10) : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {3'b000, r.line, r.wdata, r.addr, r.rnw, r.apndp};
        s_axis_tuser  <= r.action;
        do begin
            @(posedge i_clk);
        end while (!s_axis_tready);
        was_idle = (eng_phase == ENG_IDLE);
        has_cyc  = predict_line_cycle(r, cyc);
        if (has_cyc) pending_cycles.push_back(typed ? typed_cyc : cyc);
        // count only requests the block acts on
        if (has_cyc || (was_idle && (r.action == swd_bte_pkg::ACT_START_XFER
                                     || r.action == swd_bte_pkg::ACT_START_JSEQ)))
            items_sent++;
    endtask

    // Tick the running transfer or sequence to its end, with the odd ignored
    // request (start while busy, unused action) dropped in between.
    task automatic finish_sequence();
        t_swd_req r;
        while (eng_phase != ENG_IDLE) begin
            r = random_fields();
            if ($urandom_range(0, 29) == 0) begin
                r.action = ($urandom_range(0, 2) == 0) ? ACT_UNUSED :
                           ($urandom_range(0, 1) ? swd_bte_pkg::ACT_START_XFER
                                                 : swd_bte_pkg::ACT_START_JSEQ);
            end else begin
                r.line = line_for_tick();
            end
            send_request(r, 1'b0, NO_CYCLE);
        end
    endtask

    // Drop valid, wait until every owed cycle has come out, then let the
    // output stage empty before anything else touches the block.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (pending_cycles.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Result side: random stalls per result, plus the long hold-off when asked
    initial begin : result_sink
        int stall;
        m_axis_tready = 1'b0;
        @(posedge i_clk);
        forever begin
            stall = rx_gaps ? $urandom_range(0, 10) : 0;
            if (stall > 0 || hold_off) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
                while (hold_off) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do begin
                @(posedge i_clk);
            end while (!(m_axis_tvalid && m_axis_tready));
            check_result(m_axis_tdata, m_axis_tlast);
        end
    end

    // Long receiver hold-off: the block must fill its output stage and stall
    // the request side while the sender keeps offering.
    initial begin : long_hold
        wait (hold_go);
        @(posedge i_clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_off <= 1'b0;
    end

    // Watchdog: end the run if it hangs
    initial begin : watchdog
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("*** FAILED ***");
        $finish;
    end

    initial begin : stimulus
        t_swd_req r;
        int       pick;
        int       setting_end;
        i_rst_n       = 1'b0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_wr_data = 3'd0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = swd_bte_pkg::ACT_TICK;

        // Directed requests at the reset turnaround setting: an AP write
        // to A3:A2 = 3 that the target answers with WAIT, then the start of a
        // switch sequence, with ignored requests in between.
        dir_rows = '{
            '{TICK1, 1'b0, NO_CYCLE},                                      // tick while idle
            '{'{ACT_UNUSED, 1'b1, 1'b1, 2'd3, 32'hFFFF_FFFF, 1'b1}, 1'b0, NO_CYCLE},
            '{'{swd_bte_pkg::ACT_START_XFER, 1'b1, 1'b0, 2'd3, 32'hFFFF_FFFF, 1'b0},
              1'b0, NO_CYCLE},
            '{TICK1, 1'b1, DRV_1},                                         // start bit
            '{TICK0, 1'b1, DRV_1},                                         // APnDP
            '{JSEQ0, 1'b0, NO_CYCLE},                                      // start while busy
            '{TICK0, 1'b1, DRV_0},                                         // RnW
            '{TICK1, 1'b1, DRV_1},                                         // A2
            '{TICK0, 1'b1, DRV_1},                                         // A3
            '{TICK1, 1'b1, DRV_1},                                         // parity
            '{TICK0, 1'b1, DRV_0},                                         // stop
            '{TICK1, 1'b1, DRV_1},                                         // park
            '{TICK1, 1'b1, NO_CYCLE},                                      // turnaround
            '{TICK0, 1'b1, NO_CYCLE},                                      // ack, LSB first
            '{TICK1, 1'b1, NO_CYCLE},
            '{TICK0, 1'b1, NO_CYCLE},
            '{TICK1, 1'b1, WAIT_END},                                      // closing turnaround
            '{JSEQ0, 1'b0, NO_CYCLE},
            '{TICK0, 1'b1, DRV_1},                                         // leading ones
            '{TICK1, 1'b1, DRV_1},
            '{'{swd_bte_pkg::ACT_START_XFER, 1'b0, 1'b1, 2'd0, 32'd0, 1'b1}, 1'b0, NO_CYCLE},
            '{TICK0, 1'b1, DRV_1}
        };

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[i]) send_request(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].want);
        finish_sequence();
        settle();

        // One stretch per turnaround setting, out-of-range values included
        foreach (turn_plan[p]) begin
            // leave one stretch without any idling on either side
            tx_gaps = (p != 1 && p != 4);
            rx_gaps = (p != 3 && p != 4);

            i_cfg_wr_en   <= 1'b1;
            i_cfg_wr_data <= turn_plan[p];
            @(posedge i_clk);
            turn_cfg = turn_plan[p];
            i_cfg_wr_en <= 1'b0;

            if (p == 2) hold_go = 1'b1;

            setting_end = items_sent + ITEMS_PER_SETTING;
            while (items_sent < setting_end) begin
                pick = $urandom_range(0, 99);
                r    = random_fields();
                if (pick < 3) begin
                    // JTAG-to-SWD switch sequence
                    r.action = swd_bte_pkg::ACT_START_JSEQ;
                    send_request(r, 1'b0, NO_CYCLE);
                    finish_sequence();
                end else if (pick < 10) begin
                    // requests the idle block must ignore
                    r.action = (pick < 7) ? swd_bte_pkg::ACT_TICK : ACT_UNUSED;
                    send_request(r, 1'b0, NO_CYCLE);
                end else begin
                    // full transfer; mostly OK, with WAIT, FAULT and junk acks
                    pick = $urandom_range(0, 99);
                    planned_ack = (pick < 60) ? swd_bte_pkg::ACK_OK :
                                  (pick < 72) ? swd_bte_pkg::ACK_WAIT :
                                  (pick < 84) ? swd_bte_pkg::ACK_FAULT :
                                  3'($urandom_range(0, 7));
                    r.action = swd_bte_pkg::ACT_START_XFER;
                    send_request(r, 1'b0, NO_CYCLE);
                    finish_sequence();
                end
            end
            settle();
        end

        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/swd_bte_pkg.sv
rtl/core/swd_bit_transfer_engine_top.sv
bench/swd_bit_transfer_engine_top_tb.sv
